FILE: sv/hej_pkg.sv
// Package for the hash equi-join block: sizes, status codes, transaction types.
// No dependencies.
`timescale 1ns / 1ps
package hej_pkg;
  localparam int unsigned TableEntries = 1024;
  localparam int unsigned PayloadBits  = 64;
  localparam int unsigned IdxW         = $clog2(TableEntries);
  localparam int unsigned CntW         = IdxW + 1;
  localparam int unsigned KeyW         = 31;
  localparam int unsigned QDepth       = 2;

  localparam logic [31:0] HashMult = 32'd2654435761;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_HIT       = 3'd3,
    ST_MISS      = 3'd4
  } status_e;

  typedef enum logic {
    CMD_BUILD = 1'b0,
    CMD_PROBE = 1'b1
  } command_e;

  typedef struct packed {
    logic        command;
    logic [30:0] join_key;
    logic [63:0] record_payload;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [30:0] matched_key;
    logic [63:0] probe_payload;
    logic [63:0] build_payload;
  } out_item_t;

  // Classified job handed from the front end to the table walker.
  typedef struct packed {
    logic                   command;
    logic [KeyW-1:0]        join_key;
    logic [PayloadBits-1:0] payload;
    logic [IdxW-1:0]        home;
  } job_t;

  function automatic logic [PayloadBits-1:0] trim_pay(input logic [63:0] p);
    return p[PayloadBits-1:0];
  endfunction
endpackage

FILE: sv/hej_front.sv
// Front end: accepts input transactions, computes the home slot, queues jobs.
// Depends on hej_pkg.
`timescale 1ns / 1ps
module hej_front import hej_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_data_i,
  output logic     job_valid_o,
  input  logic     job_take_i,
  output job_t     job_o
);
  // Stage 1: register input and home slot.
  logic            s1_q;
  in_item_t        s1_item_q;
  logic [IdxW-1:0] s1_home_q;
  job_t            q_mem_q [QDepth];
  logic [0:0]      wr_q, rd_q;
  logic [1:0]      cnt_q;
  logic            s1_push;
  logic            accept;

  assign s1_push    = s1_q && (cnt_q < 2'(QDepth));
  assign in_stall_o = s1_q && !s1_push;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= 1'b0;
    end else if (accept) begin
      s1_q <= 1'b1;
    end else if (s1_push) begin
      s1_q <= 1'b0;
    end
  end

  // Only the low index bits of key * multiplier select the slot.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= in_data_i;
      s1_home_q <= IdxW'(in_data_i.join_key[IdxW-1:0] * HashMult[IdxW-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (s1_push) wr_q <= wr_q + 1'b1;
      if (job_take_i) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + 2'(s1_push) - 2'(job_take_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_push) begin
      q_mem_q[wr_q] <= '{command:  s1_item_q.command,
                         join_key: s1_item_q.join_key,
                         payload:  trim_pay(s1_item_q.record_payload),
                         home:     s1_home_q};
    end
  end

  assign job_valid_o = cnt_q != 2'd0;
  assign job_o       = q_mem_q[rd_q];

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(QDepth)) else $error("queue count overflow");
  a_no_take_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_take_i |-> job_valid_o) else $error("take from empty queue");
  a_push_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_push && !job_take_i) |=> cnt_q == $past(cnt_q) + 2'd1)
    else $error("queue count missed push");
endmodule

FILE: sv/hej_back.sv
// Back end: walks the open-addressed table by linear probing, one slot per
// read, and produces one result per job. Depends on hej_pkg.
`timescale 1ns / 1ps
module hej_back import hej_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      job_valid_i,
  output logic      job_take_o,
  input  job_t      job_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);
  typedef enum logic [4:0] {
    S_CLR  = 5'b00001,
    S_IDLE = 5'b00010,
    S_READ = 5'b00100,
    S_CHK  = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

  state_e                 state_q, state_d;
  logic [KeyW-1:0]        key_mem [TableEntries];
  logic [PayloadBits-1:0] pay_mem [TableEntries];
  logic                   valid_mem [TableEntries];
  logic [IdxW-1:0]        clr_q;
  logic [CntW-1:0]        used_q;
  job_t                   job_q;
  logic [IdxW-1:0]        idx_q;
  logic [CntW-1:0]        n_q;
  logic [KeyW-1:0]        rkey_q;
  logic [PayloadBits-1:0] rpay_q;
  logic                   rvalid_q;
  logic                   ov_q;
  out_item_t              out_q;
  logic                   out_free;
  logic                   wr_en;
  logic                   done;
  out_item_t              res;

  assign out_free   = !ov_q || !out_stall_i;
  assign job_take_o = (state_q == S_IDLE) && job_valid_i;

  always_comb begin
    res       = '0;
    wr_en     = 1'b0;
    done      = 1'b0;
    res.matched_key = job_q.join_key;
    if (job_q.command == CMD_PROBE) res.probe_payload = 64'(job_q.payload);
    if (n_q == CntW'(TableEntries)) begin
      done       = 1'b1;
      res.status = (job_q.command == CMD_BUILD) ? ST_FULL : ST_MISS;
    end else if (!rvalid_q) begin
      done = 1'b1;
      if (job_q.command == CMD_BUILD) begin
        res.status = ST_INSERTED;
        wr_en      = 1'b1;
      end else begin
        res.status = ST_MISS;
      end
    end else if (rkey_q == job_q.join_key) begin
      done = 1'b1;
      if (job_q.command == CMD_BUILD) begin
        res.status = ST_DUPLICATE;
      end else begin
        res.status        = ST_HIT;
        res.build_payload = 64'(rpay_q);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLR:  if (clr_q == IdxW'(TableEntries - 1)) state_d = S_IDLE;
      S_IDLE: if (job_valid_i) state_d = S_READ;
      S_READ: state_d = S_CHK;
      S_CHK:  if (done) state_d = S_OUT; else state_d = S_READ;
      S_OUT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      used_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLR) clr_q <= clr_q + 1'b1;
      if (state_q == S_CHK && wr_en) used_q <= used_q + 1'b1;
      if (state_q == S_OUT && out_free) ov_q <= 1'b1;
      else if (!out_stall_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_take_o) begin
      job_q <= job_i;
      idx_q <= job_i.home;
      n_q   <= '0;
    end
    if (state_q == S_READ) begin
      rkey_q   <= key_mem[idx_q];
      rpay_q   <= pay_mem[idx_q];
      rvalid_q <= valid_mem[idx_q];
    end
    // Zero the valid marks one slot per cycle after reset.
    if (state_q == S_CLR) begin
      valid_mem[clr_q] <= 1'b0;
    end else if (state_q == S_CHK && wr_en) begin
      key_mem[idx_q]   <= job_q.join_key;
      pay_mem[idx_q]   <= job_q.payload;
      valid_mem[idx_q] <= 1'b1;
    end
    if (state_q == S_CHK && !done) begin
      idx_q <= idx_q + 1'b1;
      n_q   <= n_q + 1'b1;
    end
    // Load the result only once the output register is free.
    if (state_q == S_OUT && out_free) out_q <= res;
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CntW'(TableEntries)) else $error("entry count overflow");
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && !out_free) |=> state_q == S_OUT)
    else $error("result dropped under stall");
endmodule

FILE: sv/hash_equi_join.sv
// Hash equi-join, build and probe on a 31-bit key over a linear-probing table.
// The back end walks the single-port slot memory for one job at a time; the front
// end queues further jobs meanwhile. Reset clears the entry count; a pass over
// all 1024 slots then zeroes the slot valid marks before the first job is taken.
// Depends on hej_pkg, hej_front, hej_back.
`timescale 1ns / 1ps
module hash_equi_join import hej_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);
  logic job_valid;
  logic job_take;
  job_t job;

  hej_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .job_valid_o(job_valid), .job_take_i(job_take), .job_o(job)
  );

  hej_back u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_take_o(job_take),
    .job_i(job), .out_valid_o, .out_stall_i, .out_data_o
  );
endmodule

FILE: test/hej_checker.sv
// Checker for the hash equi-join block: watches both channels, predicts each
// result with its own hash table copy, and compares. Depends on hej_pkg.
`timescale 1ns / 1ps
module hej_checker import hej_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_data_i,
  output int        fail_count_o,
  output int        pending_o
);
  localparam int unsigned ExpDepth = 256;

  logic [KeyW-1:0] tbl_key [TableEntries];
  logic [63:0]     tbl_pay [TableEntries];
  logic            tbl_vld [TableEntries];
  out_item_t       exp_fifo [ExpDepth];
  int unsigned     exp_wr = 0;
  int unsigned     exp_rd = 0;

  task automatic report_mismatch(input string what, input out_item_t got, input out_item_t exp);
    $display("mismatch %s: got st=%0d key=%h pp=%h bp=%h exp st=%0d key=%h pp=%h bp=%h",
             what, got.status, got.matched_key, got.probe_payload, got.build_payload,
             exp.status, exp.matched_key, exp.probe_payload, exp.build_payload);
    fail_count_o++;
  endtask

  function automatic out_item_t predict_join(input in_item_t it);
    out_item_t r;
    logic [63:0] prod;
    int unsigned idx;
    int unsigned pos;
    bit found;
    r = '0;
    prod = 64'(it.join_key) * 64'(HashMult);
    idx = int'(prod % TableEntries);
    pos = TableEntries;
    found = 0;
    for (int n = 0; n < TableEntries; n++) begin
      if (!tbl_vld[idx]) begin
        pos = idx;
        break;
      end
      if (tbl_key[idx] == it.join_key) begin
        pos = idx;
        found = 1;
        break;
      end
      idx = (idx + 1) % TableEntries;
    end
    r.matched_key = it.join_key;
    if (it.command == CMD_BUILD) begin
      if (found) r.status = ST_DUPLICATE;
      else if (pos < TableEntries) begin
        tbl_key[pos] = it.join_key;
        tbl_pay[pos] = it.record_payload;
        tbl_vld[pos] = 1;
        r.status = ST_INSERTED;
      end else r.status = ST_FULL;
    end else begin
      r.probe_payload = it.record_payload;
      if (found) begin
        r.status = ST_HIT;
        r.build_payload = tbl_pay[pos];
      end else r.status = ST_MISS;
    end
    return r;
  endfunction

  initial begin
    fail_count_o = 0;
    for (int i = 0; i < TableEntries; i++) tbl_vld[i] = 0;
  end

  assign pending_o = int'(exp_wr - exp_rd);

  always @(posedge clk_i) begin
    out_item_t exp;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (exp_wr == exp_rd) report_mismatch("unexpected", out_data_i, '0);
        else begin
          exp = exp_fifo[exp_rd % ExpDepth];
          exp_rd++;
          if (out_data_i.status !== exp.status) report_mismatch("status", out_data_i, exp);
          else if (out_data_i.matched_key !== exp.matched_key)
            report_mismatch("key", out_data_i, exp);
          else if (out_data_i.probe_payload !== exp.probe_payload)
            report_mismatch("probe payload", out_data_i, exp);
          else if (out_data_i.build_payload !== exp.build_payload)
            report_mismatch("build payload", out_data_i, exp);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        exp_fifo[exp_wr % ExpDepth] = predict_join(in_data_i);
        exp_wr++;
      end
    end
  end
endmodule

FILE: test/tb_top.sv
// Testbench top for the hash equi-join block: clock, reset, stimulus, idling
// phases and verdict. Depends on hej_pkg, hash_equi_join and hej_checker.
`timescale 1ns / 1ps
module tb_top;
  import hej_pkg::*;
  logic      clk_i = 0;
  logic      rst_ni = 0;
  logic      in_valid = 0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 0;
  out_item_t out_data;
  int        fail_count;
  int        pending;
  int        send_idle_pct = 0;
  int        stall_pct = 0;
  int        hold_off = 0;
  int        cycles = 0;
  logic [30:0] key_pool [64];

  always #2 clk_i = ~clk_i;

  hash_equi_join dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data)
  );

  hej_checker u_chk (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Receiver stall: random by phase, or a long counted hold-off.
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      out_stall <= 1;
      hold_off <= hold_off - 1;
    end else out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offer one transaction; hold it until accepted, then maybe idle.
  task automatic send_item(input logic cmd, input logic [30:0] key, input logic [63:0] pay);
    in_valid <= 1;
    in_data <= '{command: cmd, join_key: key, record_payload: pay};
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk_i);
    end
  endtask

  task automatic send_random(input int count);
    logic [30:0] k;
    logic [63:0] p;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) < 8) k = key_pool[$urandom_range(63)];
      else k = 31'($urandom);
      p = {$urandom, $urandom};
      send_item(1'($urandom_range(1)), k, p);
    end
  endtask

  initial begin
    for (int i = 0; i < 64; i++) key_pool[i] = 31'($urandom);
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // Directed: probe on empty table, extremes, duplicate, hit, miss.
    send_item(CMD_PROBE, '0, '1);
    send_item(CMD_BUILD, '0, '1);
    send_item(CMD_BUILD, '1, '0);
    send_item(CMD_BUILD, '0, 64'h1234);
    send_item(CMD_PROBE, '0, '0);
    send_item(CMD_PROBE, '1, '1);
    send_item(CMD_PROBE, 31'h2AAAAAAA, 64'h5555_5555_5555_5555);
    // Colliding keys share a home slot: key + k*1024 keeps the low bits.
    for (int i = 0; i < 6; i++) send_item(CMD_BUILD, 31'(5 + i * 1024), 64'(i));
    for (int i = 0; i < 7; i++) send_item(CMD_PROBE, 31'(5 + i * 1024), {$urandom, $urandom});
    send_random(150);
    send_idle_pct = 88;
    send_random(150);
    send_idle_pct = 0;
    stall_pct = 88;
    send_random(150);
    send_idle_pct = 15;
    stall_pct = 15;
    send_random(150);
    send_idle_pct = 0;
    stall_pct = 0;
    @(posedge clk_i);
    hold_off <= 300;
    send_random(80);
    // Duplicate of an early key, then a probe for an absent key.
    send_item(CMD_BUILD, '0, 64'h77);
    send_item(CMD_PROBE, 31'h0BADCAFE, '1);
    send_random(30);
    in_valid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule

FILE: files.f
sv/hej_pkg.sv
sv/hej_front.sv
sv/hej_back.sv
sv/hash_equi_join.sv
test/hej_checker.sv
test/tb_top.sv
